FILE: design/log_record_deframer_crc_core_defines.svh
// assertion macros shared by the deframer rtl
`ifndef LOG_RECORD_DEFRAMER_CRC_CORE_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_CRC_CORE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define LRDC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define LRDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the trigger
`define LRDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lrdc_pkg.sv
package lrdc_pkg;

    // record layout
    localparam int unsigned HDR_BYTES = 14;
    localparam int unsigned VER_BYTES = 8;
    localparam int unsigned KL_END    = 10;
    localparam int unsigned CRC_BYTES = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // default depth of the result queue
    localparam int unsigned LRDC_FIFO_DEPTH = 4;

    // result kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_CRC_BAD   = 2'd1;
    localparam logic [1:0] STAT_TRUNC_HDR = 2'd2;
    localparam logic [1:0] STAT_TRUNC_REC = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_KEY    = 3'd1,
        PH_VALUE  = 3'd2,
        PH_CRC    = 3'd3,
        PH_HALT   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [63:0] version;
        logic [15:0] key_length;
        logic [31:0] value_length;
        logic [1:0]  status;
        logic [47:0] record_offset;
        logic        stream_end;
        logic        last;
    } result_t;

    // reflected crc-32 over one byte, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // assemble one result item, header fields only when asked for
    function automatic result_t make_result(
        input logic [1:0]  kind,
        input logic [7:0]  pay,
        input logic        hdr,
        input logic [1:0]  status,
        input logic [63:0] ver,
        input logic [15:0] kl,
        input logic [31:0] vl,
        input logic [47:0] offset
    );
        result_t r;
        r.kind          = kind;
        r.payload_byte  = pay;
        r.version       = hdr ? ver : 64'd0;
        r.key_length    = hdr ? kl : 16'd0;
        r.value_length  = hdr ? vl : 32'd0;
        r.status        = status;
        r.record_offset = offset;
        r.stream_end    = 1'b0;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

FILE: design/log_record_deframer_crc_core.sv
// a result item is written into the result queue as its byte is accepted and is shown on the
//   m_ side once it reaches the queue head; bytes are taken one per cycle while s_ready is high,
//   and a byte that causes two result items is absorbed by the result queue of FIFO_DEPTH entries
// s_ready is high while the queue has room for two result items; cfg_ready is always high
// reset (aresetn low, synchronous): header phase, position 0, region length 0, queue empty
module log_record_deframer_crc_core
    import lrdc_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = LRDC_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [47:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [63:0] m_version,
    output logic [15:0] m_key_length,
    output logic [31:0] m_value_length,
    output logic [1:0]  m_status,
    output logic [47:0] m_record_offset,
    output logic        m_stream_end,
    output logic        m_last
);

`include "log_record_deframer_crc_core_defines.svh"

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    // scan state
    logic [47:0] region_length_reg;
    logic [47:0] pos_reg,      pos_next;
    phase_t      phase_reg,    phase_next;
    logic [31:0] count_reg,    count_next;
    logic [63:0] ver_reg,      ver_next;
    logic [15:0] kl_reg,       kl_next;
    logic [31:0] vl_reg,       vl_next;
    logic [31:0] crc_reg,      crc_next;
    logic [31:0] rcv_reg,      rcv_next;
    logic [47:0] start_reg,    start_next;

    // result queue
    result_t          fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] fcount_reg;

    logic    s_accept;
    logic    active;
    logic    ended;
    logic    push0, push1;
    logic    pop;
    result_t res0, res1, trunc_res;
    logic    trunc_v;
    logic [1:0] vl_idx;

    assign cfg_ready = 1'b1;
    assign s_ready   = (fcount_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_accept  = s_valid && s_ready;
    assign active    = s_accept && (phase_reg != PH_HALT) && (pos_reg < region_length_reg);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // region length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_length_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            region_length_reg <= cfg_data;
        end
    end

    // per-byte parse, crc and result build
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        ver_next   = ver_reg;
        kl_next    = kl_reg;
        vl_next    = vl_reg;
        crc_next   = crc_reg;
        rcv_next   = rcv_reg;
        start_next = start_reg;
        ended      = 1'b0;
        push0      = 1'b0;
        push1      = 1'b0;
        res0       = '0;
        res1       = '0;
        trunc_res  = '0;
        trunc_v    = 1'b0;
        vl_idx     = 2'(count_reg[3:0] - 4'(KL_END));

        if (active) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    // first header byte opens a new record
                    if (count_reg == 32'd0) begin
                        start_next = pos_reg;
                        ver_next   = '0;
                        kl_next    = '0;
                        vl_next    = '0;
                        rcv_next   = '0;
                        crc_next   = crc_byte(32'hFFFF_FFFF, s_data_byte);
                    end else begin
                        crc_next   = crc_byte(crc_reg, s_data_byte);
                    end
                    if (count_reg < 32'(VER_BYTES)) begin
                        ver_next[{count_reg[2:0], 3'b000} +: 8] = s_data_byte;
                    end else if (count_reg < 32'(KL_END)) begin
                        kl_next[{count_reg[0], 3'b000} +: 8] = s_data_byte;
                    end else begin
                        vl_next[{vl_idx, 3'b000} +: 8] = s_data_byte;
                    end
                    count_next = count_reg + 32'd1;
                    if (count_next >= 32'(HDR_BYTES)) begin
                        count_next = '0;
                        if (kl_next != 16'd0) begin
                            phase_next = PH_KEY;
                        end else if (vl_next != 32'd0) begin
                            phase_next = PH_VALUE;
                        end else begin
                            phase_next = PH_CRC;
                        end
                    end
                end
                PH_KEY: begin
                    crc_next   = crc_byte(crc_reg, s_data_byte);
                    res0       = make_result(KIND_KEY, s_data_byte, 1'b0, STAT_OK,
                                             ver_reg, kl_reg, vl_reg, start_reg);
                    push0      = 1'b1;
                    count_next = count_reg + 32'd1;
                    if (count_next >= {16'd0, kl_reg}) begin
                        count_next = '0;
                        phase_next = (vl_reg != 32'd0) ? PH_VALUE : PH_CRC;
                    end
                end
                PH_VALUE: begin
                    crc_next   = crc_byte(crc_reg, s_data_byte);
                    res0       = make_result(KIND_VALUE, s_data_byte, 1'b0, STAT_OK,
                                             ver_reg, kl_reg, vl_reg, start_reg);
                    push0      = 1'b1;
                    count_next = count_reg + 32'd1;
                    if (count_next >= vl_reg) begin
                        count_next = '0;
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC: begin
                    // stored crc arrives little-endian
                    rcv_next[{count_reg[1:0], 3'b000} +: 8] = s_data_byte;
                    count_next = count_reg + 32'd1;
                    if (count_next >= 32'(CRC_BYTES)) begin
                        count_next = '0;
                        push0      = 1'b1;
                        if (~crc_reg == rcv_next) begin
                            res0       = make_result(KIND_DONE, 8'd0, 1'b1, STAT_OK,
                                                     ver_reg, kl_reg, vl_reg, start_reg);
                            phase_next = PH_HEADER;
                        end else begin
                            res0       = make_result(KIND_ERROR, 8'd0, 1'b1, STAT_CRC_BAD,
                                                     ver_reg, kl_reg, vl_reg, start_reg);
                            phase_next = PH_HALT;
                            ended      = 1'b1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_HALT;
                end
            endcase

            pos_next = pos_reg + 48'd1;

            // region end: report a cut-off header or record and stop
            if (!ended && (pos_next >= region_length_reg)) begin
                ended = 1'b1;
                if ((phase_next == PH_HEADER) && (count_next != 32'd0)) begin
                    trunc_res = make_result(KIND_ERROR, 8'd0, 1'b0, STAT_TRUNC_HDR,
                                            ver_next, kl_next, vl_next, start_next);
                    trunc_v   = 1'b1;
                end else if ((phase_next == PH_KEY) || (phase_next == PH_VALUE) ||
                             (phase_next == PH_CRC)) begin
                    trunc_res = make_result(KIND_ERROR, 8'd0, 1'b1, STAT_TRUNC_REC,
                                            ver_next, kl_next, vl_next, start_next);
                    trunc_v   = 1'b1;
                end
                phase_next = PH_HALT;
            end

            // place the truncation item and mark the final item of this byte
            if (trunc_v) begin
                if (push0) begin
                    res1  = trunc_res;
                    push1 = 1'b1;
                end else begin
                    res0  = trunc_res;
                    push0 = 1'b1;
                end
            end
            if (push1) begin
                res1.last       = 1'b1;
                res1.stream_end = ended;
            end else if (push0) begin
                res0.last       = 1'b1;
                res0.stream_end = ended;
            end
        end
    end

    // scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            ver_reg   <= '0;
            kl_reg    <= '0;
            vl_reg    <= '0;
            crc_reg   <= 32'hFFFF_FFFF;
            rcv_reg   <= '0;
            start_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            ver_reg   <= ver_next;
            kl_reg    <= kl_next;
            vl_reg    <= vl_next;
            crc_reg   <= crc_next;
            rcv_reg   <= rcv_next;
            start_reg <= start_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (push0) begin
            fifo_mem[wptr_reg] <= res0;
        end
        if (push1) begin
            fifo_mem[ptr_inc(wptr_reg)] <= res1;
        end
    end

    // result queue pointers and fill count
    assign pop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            fcount_reg <= '0;
        end else begin
            if (push1) begin
                wptr_reg <= ptr_inc(ptr_inc(wptr_reg));
            end else if (push0) begin
                wptr_reg <= ptr_inc(wptr_reg);
            end
            if (pop) begin
                rptr_reg <= ptr_inc(rptr_reg);
            end
            fcount_reg <= fcount_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
        end
    end

    // output side
    assign m_valid         = (fcount_reg != '0);
    assign m_kind          = fifo_mem[rptr_reg].kind;
    assign m_payload_byte  = fifo_mem[rptr_reg].payload_byte;
    assign m_version       = fifo_mem[rptr_reg].version;
    assign m_key_length    = fifo_mem[rptr_reg].key_length;
    assign m_value_length  = fifo_mem[rptr_reg].value_length;
    assign m_status        = fifo_mem[rptr_reg].status;
    assign m_record_offset = fifo_mem[rptr_reg].record_offset;
    assign m_stream_end    = fifo_mem[rptr_reg].stream_end;
    assign m_last          = fifo_mem[rptr_reg].last;

    // checks
    `LRDC_ASSERT_ALWAYS(a_fifo_bound, fcount_reg <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `LRDC_ASSERT_NEXT(a_halt_sticky, phase_reg == PH_HALT, phase_reg == PH_HALT, "left halt without reset")
    `LRDC_ASSERT_NEXT(a_error_halts, push0 && (res0.kind == KIND_ERROR), phase_reg == PH_HALT, "error item did not halt the scan")
    `LRDC_ASSERT_SAME(a_done_from_crc, push0 && (res0.kind == KIND_DONE), phase_reg == PH_CRC, "record finished outside crc phase")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lrdc_pkg::*;

    localparam logic [47:0] FULL_REGION = 48'hFFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 8;
    localparam int SCAN_TARGET = 1250;
    localparam int MAX_PRINTED = 200;
    localparam longint TIMEOUT_NS = 2_000_000;

    // how the scan is brought to its end
    typedef enum int {
        END_CLEAN,
        END_CRC_BAD,
        END_TRUNC_HDR,
        END_TRUNC_REC
    } ending_t;

    // mirror of the deframer state plus the queue of results still owed
    class record_scoreboard;
        result_t     pending_results[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned records_done;
        logic [47:0] region_len;
        logic [47:0] pos;
        logic [47:0] rec_start;
        phase_t      ph;
        int unsigned cnt;
        logic [63:0] ver;
        logic [15:0] klen;
        logic [31:0] vlen;
        logic [31:0] crc;
        logic [31:0] rx_crc;

        function new();
            mismatches   = 0;
            checked      = 0;
            records_done = 0;
            region_len   = '0;
            pos          = '0;
            rec_start    = '0;
            ph           = PH_HEADER;
            cnt          = 0;
            ver          = '0;
            klen         = '0;
            vlen         = '0;
            crc          = '1;
            rx_crc       = '0;
        endfunction

        // serial lfsr form of the reflected crc-32, one data bit per shift
        static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            logic        fb;
            r = c;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ b[i];
                r  = r >> 1;
                if (fb) r = r ^ CRC_POLY;
            end
            return r;
        endfunction

        function void set_region(logic [47:0] v);
            region_len = v;
        endfunction

        function result_t expected_item(logic [1:0] kind, logic [7:0] pay, bit hdr,
                                        logic [1:0] stat);
            result_t e;
            e.kind          = kind;
            e.payload_byte  = pay;
            e.version       = hdr ? ver : 64'd0;
            e.key_length    = hdr ? klen : 16'd0;
            e.value_length  = hdr ? vlen : 32'd0;
            e.status        = stat;
            e.record_offset = rec_start;
            e.stream_end    = 1'b0;
            e.last          = 1'b0;
            return e;
        endfunction

        // advance the parser by one accepted byte and queue what it owes
        function void note_byte(logic [7:0] b);
            result_t produced[$];
            bit      ended;
            ended = 1'b0;
            if (ph == PH_HALT || pos >= region_len) return;

            case (ph)
                PH_HEADER: begin
                    if (cnt == 0) begin
                        rec_start = pos;
                        crc       = '1;
                        ver       = '0;
                        klen      = '0;
                        vlen      = '0;
                        rx_crc    = '0;
                    end
                    crc = crc_next(crc, b);
                    if (cnt < VER_BYTES) ver[8*cnt +: 8] = b;
                    else if (cnt < KL_END) klen[8*(cnt-VER_BYTES) +: 8] = b;
                    else vlen[8*(cnt-KL_END) +: 8] = b;
                    cnt++;
                    if (cnt >= HDR_BYTES) begin
                        cnt = 0;
                        if (klen != 0) ph = PH_KEY;
                        else if (vlen != 0) ph = PH_VALUE;
                        else ph = PH_CRC;
                    end
                end
                PH_KEY: begin
                    crc = crc_next(crc, b);
                    produced.push_back(expected_item(KIND_KEY, b, 1'b0, STAT_OK));
                    cnt++;
                    if (cnt >= klen) begin
                        cnt = 0;
                        if (vlen != 0) ph = PH_VALUE;
                        else ph = PH_CRC;
                    end
                end
                PH_VALUE: begin
                    crc = crc_next(crc, b);
                    produced.push_back(expected_item(KIND_VALUE, b, 1'b0, STAT_OK));
                    cnt++;
                    if (cnt >= vlen) begin
                        cnt = 0;
                        ph  = PH_CRC;
                    end
                end
                default: begin
                    rx_crc[8*(cnt%4) +: 8] = b;
                    cnt++;
                    if (cnt >= CRC_BYTES) begin
                        if (~crc == rx_crc) begin
                            produced.push_back(expected_item(KIND_DONE, 8'd0, 1'b1, STAT_OK));
                            ph = PH_HEADER;
                            records_done++;
                        end else begin
                            produced.push_back(
                                expected_item(KIND_ERROR, 8'd0, 1'b1, STAT_CRC_BAD));
                            ph    = PH_HALT;
                            ended = 1'b1;
                        end
                        cnt = 0;
                    end
                end
            endcase

            pos = pos + 48'd1;

            // region end: report whatever record is left open
            if (!ended && pos >= region_len) begin
                ended = 1'b1;
                if (ph == PH_HEADER && cnt != 0)
                    produced.push_back(expected_item(KIND_ERROR, 8'd0, 1'b0, STAT_TRUNC_HDR));
                else if (ph == PH_KEY || ph == PH_VALUE || ph == PH_CRC)
                    produced.push_back(expected_item(KIND_ERROR, 8'd0, 1'b1, STAT_TRUNC_REC));
                ph = PH_HALT;
            end

            if (produced.size() > 0) begin
                produced[produced.size()-1].last = 1'b1;
                if (ended) produced[produced.size()-1].stream_end = 1'b1;
            end
            foreach (produced[i]) pending_results.push_back(produced[i]);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTED)
                $display("mismatch at result %0d: %s", checked, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] got_v, logic [63:0] exp_v);
            if (got_v !== exp_v)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, exp_v));
        endtask

        // oldest expectation against the item just taken from the block
        task check_result(result_t got);
            result_t e;
            if (pending_results.size() == 0) begin
                report_mismatch("result item with nothing expected");
                return;
            end
            e = pending_results.pop_front();
            checked++;
            compare_field("kind", got.kind, e.kind);
            compare_field("payload_byte", got.payload_byte, e.payload_byte);
            compare_field("version", got.version, e.version);
            compare_field("key_length", got.key_length, e.key_length);
            compare_field("value_length", got.value_length, e.value_length);
            compare_field("status", got.status, e.status);
            compare_field("record_offset", got.record_offset, e.record_offset);
            compare_field("stream_end", got.stream_end, e.stream_end);
            compare_field("last", got.last, e.last);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [47:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [63:0] m_version;
    logic [15:0] m_key_length;
    logic [31:0] m_value_length;
    logic [1:0]  m_status;
    logic [47:0] m_record_offset;
    logic        m_stream_end;
    logic        m_last;

    record_scoreboard sb;
    result_t          seen;
    logic [7:0]       rec_bytes[$];
    int unsigned      sent_bytes = 0;
    int               hold_request = 0;
    int               hold_left = 0;
    bit               idle_on = 1'b1;

    log_record_deframer_crc_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_byte  (m_payload_byte),
        .m_version       (m_version),
        .m_key_length    (m_key_length),
        .m_value_length  (m_value_length),
        .m_status        (m_status),
        .m_record_offset (m_record_offset),
        .m_stream_end    (m_stream_end),
        .m_last          (m_last)
    );

    always #2 aclk = ~aclk;

    // result side: check taken items, then pick ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.kind          = m_kind;
            seen.payload_byte  = m_payload_byte;
            seen.version       = m_version;
            seen.key_length    = m_key_length;
            seen.value_length  = m_value_length;
            seen.status        = m_status;
            seen.record_offset = m_record_offset;
            seen.stream_end    = m_stream_end;
            seen.last          = m_last;
            sb.check_result(seen);
        end
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (idle_on) begin
            m_ready <= ($urandom_range(0, 99) >= 35);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one byte item, with a random gap ahead of it while idle_on is set
    task send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 35);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
        sent_bytes++;
    endtask

    task send_span(input int from_i, input int to_i);
        for (int i = from_i; i < to_i; i++) send_byte(rec_bytes[i]);
    endtask

    task send_noise(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    // stop offering and wait for every owed result, then let the block settle
    task drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_region(input logic [47:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_region(v);
        cfg_valid <= 1'b0;
    endtask

    task put_header(input logic [63:0] ver, input logic [15:0] kl, input logic [31:0] vl);
        rec_bytes.delete();
        for (int i = 0; i < 8; i++) rec_bytes.push_back(ver[8*i +: 8]);
        for (int i = 0; i < 2; i++) rec_bytes.push_back(kl[8*i +: 8]);
        for (int i = 0; i < 4; i++) rec_bytes.push_back(vl[8*i +: 8]);
    endtask

    // whole record with random body and stored crc, optionally damaged
    task build_record(input logic [63:0] ver, input logic [15:0] kl, input logic [31:0] vl,
                      input bit corrupt);
        logic [31:0] c;
        int          n;
        put_header(ver, kl, vl);
        for (int i = 0; i < int'(kl) + int'(vl); i++)
            rec_bytes.push_back(8'($urandom_range(0, 255)));
        c = '1;
        foreach (rec_bytes[i]) c = record_scoreboard::crc_next(c, rec_bytes[i]);
        c = ~c;
        for (int i = 0; i < 4; i++) rec_bytes.push_back(c[8*i +: 8]);
        if (corrupt) begin
            n = rec_bytes.size() - 1 - $urandom_range(0, 3);
            rec_bytes[n] = rec_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
        end
    endtask

    initial begin
        int          rec_i;
        int          cut;
        logic [15:0] kl;
        logic [31:0] vl;
        ending_t     ending_sel;

        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero region: every byte ignored
        write_region(48'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h0F);
        send_byte(8'hF0);
        drain();

        // empty record with all-ones version, then one key and one value byte
        write_region(FULL_REGION);
        build_record(64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 32'd0, 1'b0);
        send_span(0, rec_bytes.size());
        build_record(64'd0, 16'd1, 32'd1, 1'b0);
        send_span(0, rec_bytes.size());
        drain();

        // random well-formed records, mostly short
        rec_i = 0;
        while (sb.pos < SCAN_TARGET) begin
            idle_on = !(rec_i >= 12 && rec_i < 20);
            if (rec_i == 6) hold_request = 120;
            if ($urandom_range(0, 9) == 0) begin
                kl = 16'($urandom_range(0, 200));
                vl = 32'($urandom_range(0, 300));
            end else begin
                kl = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
                vl = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 16));
            end
            build_record({$urandom, $urandom}, kl, vl, 1'b0);

            if (rec_i == 4 || rec_i == 25) begin
                // park the scan mid-record by pulling the region back, then resume
                cut = $urandom_range(1, rec_bytes.size() - 1);
                send_span(0, cut);
                drain();
                write_region((rec_i == 4) ? sb.pos : 48'd0);
                send_noise(5);
                drain();
                write_region((rec_i == 4) ? FULL_REGION
                                          : {16'($urandom_range(1, 16'hFFFF)), $urandom});
                send_span(cut, rec_bytes.size());
            end else begin
                send_span(0, rec_bytes.size());
            end
            if (rec_i == 30) drain();
            rec_i++;
        end
        idle_on = 1'b1;
        drain();

        // bring the scan to an end in one of four ways
        ending_sel = ending_t'($urandom_range(0, 3));
        case (ending_sel)
            END_CLEAN: begin
                build_record({$urandom, $urandom}, 16'($urandom_range(0, 6)),
                             32'($urandom_range(0, 6)), 1'b0);
                write_region(sb.pos + 48'(rec_bytes.size()));
                send_span(0, rec_bytes.size());
            end
            END_CRC_BAD: begin
                build_record({$urandom, $urandom}, 16'($urandom_range(0, 6)),
                             32'($urandom_range(0, 6)), 1'b1);
                send_span(0, rec_bytes.size());
            end
            END_TRUNC_HDR: begin
                write_region(sb.pos + 48'($urandom_range(1, HDR_BYTES - 1)));
                send_noise(HDR_BYTES);
            end
            default: begin
                // lengths far beyond the region, bytes pass until it runs out
                put_header({$urandom, $urandom}, 16'($urandom), $urandom);
                write_region(sb.pos + 48'(HDR_BYTES) + 48'($urandom_range(0, 40)));
                send_span(0, rec_bytes.size());
                send_noise(48);
            end
        endcase
        send_noise(4);
        drain();

        // scan is halted for good: a fresh region length changes nothing
        write_region(FULL_REGION);
        send_noise(8);
        drain();
        repeat (20) @(posedge aclk);

        $display("run covered %0d byte items, %0d records finished, %0d result items checked",
                 sent_bytes, sb.records_done, sb.checked);
        $display("scan ended by %s, %0d mismatches", ending_sel.name(), sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop if the handshakes hang
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d result items outstanding", sb.pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
